@@ design/dbc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared types, tables and round functions for the Deoxys-BC cipher unit.
// ----------------------------------------------------------------------------
package dbc_pkg;

  typedef logic [0:15][7:0] blk_t;

  typedef struct packed {
    blk_t t1;
    blk_t t2;
    blk_t t3;
  } tk_t;

  typedef struct packed {
    logic [63:0] kw0;
    logic [63:0] kw1;
    logic [63:0] kw2;
    logic [63:0] kw3;
    logic        variant;
  } key_t;

  typedef struct packed {
    logic       vld;
    logic       mode;
    logic       variant;
    logic [4:0] ridx;
    blk_t       s;
    tk_t        tk;
  } stg_t;

  localparam int NumStages = 16;
  localparam logic [4:0] RoundsShort = 5'd14;
  localparam logic [4:0] RoundsLong  = 5'd16;

  localparam logic [2:0] RegKw0     = 3'd0;
  localparam logic [2:0] RegKw1     = 3'd1;
  localparam logic [2:0] RegKw2     = 3'd2;
  localparam logic [2:0] RegKw3     = 3'd3;
  localparam logic [2:0] RegVariant = 3'd4;

  localparam logic MODE_DEC = 1'b1;

  localparam logic [0:16][7:0] RCON = {
    128'h2f5ebc63c697356ad4b37dfaefc59139, 8'h72};

  localparam logic [0:15][3:0] TK_PERM = 64'h16bc5af09e34d278;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [0:255][7:0] SBOX_INV = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] xt(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] lfsr2(logic [7:0] b);
    return {b[6:0], b[7] ^ b[5]};
  endfunction

  function automatic logic [7:0] lfsr3(logic [7:0] b);
    return {b[0] ^ b[6], b[7:1]};
  endfunction

  // coefficient slot k of the circulant row, forward {2,3,1,1} or inverse {14,11,13,9}
  function automatic logic [7:0] gmul_sel(logic [7:0] b, logic [1:0] k, logic inv);
    logic [7:0] x2, x4, x8, r;
    x2 = xt(b);
    x4 = xt(x2);
    x8 = xt(x4);
    r  = 8'h00;
    if (!inv) begin
      case (k)
        2'd0:    r = x2;
        2'd1:    r = x2 ^ b;
        default: r = b;
      endcase
    end else begin
      case (k)
        2'd0:    r = x8 ^ x4 ^ x2;
        2'd1:    r = x8 ^ x2 ^ b;
        2'd2:    r = x8 ^ x4 ^ b;
        default: r = x8 ^ b;
      endcase
    end
    return r;
  endfunction

  function automatic blk_t mix(blk_t s, logic inv);
    blk_t o;
    logic [7:0] acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) begin
          acc = acc ^ gmul_sel(s[4*c+j], 2'((4 + j - r) & 3), inv);
        end
        o[4*c+r] = acc;
      end
    end
    return o;
  endfunction

  function automatic blk_t sub_shift(blk_t s);
    blk_t o;
    for (int i = 0; i < 16; i++) begin
      o[i] = SBOX[s[4*(((i >> 2) + (i & 3)) & 3) + (i & 3)]];
    end
    return o;
  endfunction

  function automatic blk_t inv_shift_sub(blk_t s);
    blk_t o;
    for (int i = 0; i < 16; i++) begin
      o[4*(((i >> 2) + (i & 3)) & 3) + (i & 3)] = SBOX_INV[s[i]];
    end
    return o;
  endfunction

  function automatic blk_t subtweakey(tk_t tk, logic [4:0] ridx);
    blk_t o;
    logic [7:0] rc;
    rc = (ridx > 5'd16) ? 8'h00 : RCON[ridx];
    o  = tk.t1 ^ tk.t2 ^ tk.t3;
    for (int i = 0; i < 4; i++) begin
      o[4*i]   = o[4*i] ^ 8'(1 << i);
      o[4*i+1] = o[4*i+1] ^ rc;
    end
    return o;
  endfunction

  function automatic tk_t tk_fwd(tk_t tk);
    tk_t o;
    for (int i = 0; i < 16; i++) begin
      o.t1[i] = tk.t1[TK_PERM[i]];
      o.t2[i] = lfsr2(tk.t2[TK_PERM[i]]);
      o.t3[i] = lfsr3(tk.t3[TK_PERM[i]]);
    end
    return o;
  endfunction

  function automatic tk_t tk_bwd(tk_t tk);
    tk_t o;
    for (int i = 0; i < 16; i++) begin
      o.t1[TK_PERM[i]] = tk.t1[i];
      o.t2[TK_PERM[i]] = lfsr3(tk.t2[i]);
      o.t3[TK_PERM[i]] = lfsr2(tk.t3[i]);
    end
    return o;
  endfunction

endpackage

@@ design/deoxys_bc_tweakable_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// deoxys_bc_tweakable_cipher_unit
// Deoxys-BC-256/384 block encrypt/decrypt, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Fully unrolled pipeline: an input stage (whitening or tweakey set-up),
// sixteen round stages and an output register; one word can enter every
// cycle unless out_stall holds the pipeline. In BC-256 the last two round
// stages pass data through. The whole pipeline holds while a result waits
// under out_stall. Key and variant are to be written by the user only while
// the unit is empty; the unit itself does not enforce this.
module deoxys_bc_tweakable_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [63:0] in_tweak_high,
  input  logic [63:0] in_tweak_low,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import dbc_pkg::*;

  key_t key;
  stg_t stg [0:NumStages];
  stg_t s0_r, s0_nxt;
  tk_t  tk_init, tk_end;
  logic [4:0] rounds;
  logic en;
  logic out_valid_r;
  blk_t res_r, res_nxt;

  assign cfg_ready = 1'b1;

  dbc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .key      (key)
  );

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    rounds     = key.variant ? RoundsLong : RoundsShort;
    tk_init.t1 = {in_tweak_high, in_tweak_low};
    if (key.variant) begin
      tk_init.t3 = {key.kw0, key.kw1};
      tk_init.t2 = {key.kw2, key.kw3};
    end else begin
      tk_init.t2 = {key.kw0, key.kw1};
      tk_init.t3 = '0;
    end
    tk_end = tk_init;
    for (int n = 0; n < NumStages; n++) begin
      if (5'(n) < rounds) begin
        tk_end = tk_fwd(tk_end);
      end
    end
    s0_nxt.vld     = in_valid;
    s0_nxt.mode    = in_mode;
    s0_nxt.variant = key.variant;
    if (in_mode == MODE_DEC) begin
      s0_nxt.s    = {in_block_high, in_block_low};
      s0_nxt.tk   = tk_end;
      s0_nxt.ridx = rounds;
    end else begin
      s0_nxt.s    = blk_t'({in_block_high, in_block_low}) ^ subtweakey(tk_init, 5'd0);
      s0_nxt.tk   = tk_fwd(tk_init);
      s0_nxt.ridx = 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (en) begin
      s0_r.vld <= s0_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.mode    <= s0_nxt.mode;
      s0_r.variant <= s0_nxt.variant;
      s0_r.ridx    <= s0_nxt.ridx;
      s0_r.s       <= s0_nxt.s;
      s0_r.tk      <= s0_nxt.tk;
    end
  end

  assign stg[0] = s0_r;

  for (genvar k = 1; k <= NumStages; k++) begin : g_round
    dbc_round #(.Stage(k)) u_round (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .prev (stg[k-1]),
      .cur  (stg[k])
    );
  end

  always_comb begin
    res_nxt = stg[NumStages].s;
    if (stg[NumStages].mode == MODE_DEC) begin
      res_nxt = stg[NumStages].s ^ subtweakey(stg[NumStages].tk, stg[NumStages].ridx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg[NumStages].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = res_r[0:7];
  assign out_result_low  = res_r[8:15];

endmodule

@@ design/dbc_cfg.sv @@
// ----------------------------------------------------------------------------
// dbc_cfg
// Key and variant registers behind the configuration write port.
// ----------------------------------------------------------------------------
module dbc_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output dbc_pkg::key_t key
);
  import dbc_pkg::*;

  key_t key_r, key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (cfg_valid) begin
      case (cfg_index)
        RegKw0:     key_nxt.kw0 = cfg_data;
        RegKw1:     key_nxt.kw1 = cfg_data;
        RegKw2:     key_nxt.kw2 = cfg_data;
        RegKw3:     key_nxt.kw3 = cfg_data;
        RegVariant: key_nxt.variant = cfg_data[0];
        default:    key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

@@ design/dbc_round.sv @@
// ----------------------------------------------------------------------------
// dbc_round
// Registered round stage: forward/inverse round + tweakey step, or bypass.
// ----------------------------------------------------------------------------
module dbc_round #(
  parameter int Stage = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  dbc_pkg::stg_t prev,
  output dbc_pkg::stg_t cur
);
  import dbc_pkg::*;

  localparam logic [4:0] StageIdx = 5'(Stage);

  stg_t cur_r, cur_nxt;
  blk_t stk;
  logic active;

  always_comb begin
    active  = StageIdx <= (prev.variant ? RoundsLong : RoundsShort);
    stk     = subtweakey(prev.tk, prev.ridx);
    cur_nxt = prev;
    if (active) begin
      if (prev.mode == MODE_DEC) begin
        cur_nxt.s    = inv_shift_sub(mix(prev.s ^ stk, 1'b1));
        cur_nxt.tk   = tk_bwd(prev.tk);
        cur_nxt.ridx = prev.ridx - 5'd1;
      end else begin
        cur_nxt.s    = mix(sub_shift(prev.s), 1'b0) ^ stk;
        cur_nxt.tk   = tk_fwd(prev.tk);
        cur_nxt.ridx = prev.ridx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
    end else if (en) begin
      cur_r.vld <= cur_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_r.mode    <= cur_nxt.mode;
      cur_r.variant <= cur_nxt.variant;
      cur_r.ridx    <= cur_nxt.ridx;
      cur_r.s       <= cur_nxt.s;
      cur_r.tk      <= cur_nxt.tk;
    end
  end

  assign cur = cur_r;

endmodule
